/* rtl/session_probe_timer_table_top_assert.svh */
// assertion macros used by the checker file
`ifndef SESSION_PROBE_TIMER_TABLE_TOP_ASSERT_SVH
`define SESSION_PROBE_TIMER_TABLE_TOP_ASSERT_SVH

// checked only while out of reset
`define SPT_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("spt assertion failed");

// checked on every edge, reset included
`define SPT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("spt assertion failed");

`endif

/* rtl/spt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spt_pkg
// Types, sizes and helpers shared by the probe timer table modules.
// ----------------------------------------------------------------------------
package spt_pkg;

    localparam int SESSIONS   = 1024;
    localparam int COUNT_BITS = 20;
    localparam int ID_W       = 10;
    localparam int CFG_W      = 20;
    localparam int CFG_IDX_W  = 1;
    localparam int ADDR_W     = $clog2(SESSIONS);
    localparam int ENTRY_W    = COUNT_BITS + 1;

    localparam logic [CFG_W-1:0] PROBE_INTERVAL_RST = CFG_W'(4883);

    localparam logic [CFG_IDX_W-1:0] REG_PROBE_INTERVAL = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_NODELAY_MODE   = CFG_IDX_W'(1);

    typedef struct packed {
        logic            set_valid;
        logic [ID_W-1:0] set_session;
        logic            clear_valid;
        logic [ID_W-1:0] clear_session;
        logic            event_ready;
    } spt_in_t;

    typedef struct packed {
        logic            set_taken;
        logic            clear_taken;
        logic            event_valid;
        logic            event_kind;
        logic [ID_W-1:0] event_session;
    } spt_out_t;

    typedef struct packed {
        logic                  active;
        logic [COUNT_BITS-1:0] count;
    } spt_entry_t;

    typedef struct packed {
        logic sweep;
        logic accept;
        logic exec;
    } spt_cmd_t;

    typedef struct packed {
        logic sweep_last;
    } spt_status_t;

    function automatic logic id_ok(logic [ID_W-1:0] id);
        return 32'(id) < 32'(SESSIONS);
    endfunction

endpackage

/* rtl/spt_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spt_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module spt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/spt_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spt_ctrl
// Sequencer: clearing pass after reset, then accept / execute per item,
// and the valid flag of the result register.
// ----------------------------------------------------------------------------
module spt_ctrl
    import spt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    output logic        m_valid,
    input  logic        m_ready,
    output spt_cmd_t    cmd,
    input  spt_status_t status
);

    typedef enum logic [2:0] {
        ST_SWEEP = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free   = !m_valid_reg || m_ready;
    assign s_ready    = (state_reg == ST_IDLE);
    assign cmd.sweep  = (state_reg == ST_SWEEP);
    assign cmd.accept = s_ready && s_valid;
    assign cmd.exec   = (state_reg == ST_EXEC) && out_free;
    assign m_valid    = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_SWEEP: begin
                if (status.sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (cmd.accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_SWEEP;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.exec) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_SWEEP;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

/* rtl/spt_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spt_datapath
// Timer RAM, scan pointer, pending set, configuration registers and the
// per-item update that builds one result.
// ----------------------------------------------------------------------------
module spt_datapath
    import spt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  spt_cmd_t             cmd,
    output spt_status_t          status,
    input  spt_in_t              s_data,
    output spt_out_t             m_data,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wr_data
);

    spt_in_t           item_reg;
    spt_out_t          out_reg, out_next;
    logic [ID_W-1:0]   scan_ptr_reg, scan_ptr_next;
    logic [ID_W-1:0]   pend_id_reg, pend_id_next;
    logic [ID_W-1:0]   last_id_reg, last_id_next;
    logic              pend_reg, pend_next;
    logic [CFG_W-1:0]  probe_interval_reg;
    logic              nodelay_mode_reg;
    logic [ADDR_W-1:0] sweep_addr_reg;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    spt_entry_t        ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    spt_entry_t        ram_rdata;
    logic [ENTRY_W-1:0] ram_rdata_raw;

    logic              ex_we;
    logic [ID_W-1:0]   ex_waddr;
    spt_entry_t        ex_wdata;
    logic [ID_W-1:0]   cur;
    logic [ID_W:0]     scan_inc;

    assign status.sweep_last = (sweep_addr_reg == ADDR_W'(SESSIONS - 1));

    // read address picked from the incoming item
    assign ram_raddr = s_data.clear_valid ? ADDR_W'(s_data.clear_session)
                                          : ADDR_W'(scan_ptr_reg);
    assign ram_rdata = spt_entry_t'(ram_rdata_raw);

    assign scan_inc = {1'b0, scan_ptr_reg} + (ID_W + 1)'(1);

    always_comb begin
        out_next      = '0;
        scan_ptr_next = scan_ptr_reg;
        pend_id_next  = pend_id_reg;
        last_id_next  = last_id_reg;
        pend_next     = pend_reg;
        ex_we         = 1'b0;
        ex_waddr      = pend_id_reg;
        ex_wdata      = '0;
        cur           = item_reg.clear_valid ? item_reg.clear_session : scan_ptr_reg;
        if (pend_reg) begin
            if (pend_id_reg != last_id_reg) begin
                ex_we          = id_ok(pend_id_reg);
                ex_wdata.active = 1'b1;
                ex_wdata.count  = COUNT_BITS'(probe_interval_reg);
                pend_next      = 1'b0;
            end
            last_id_next = last_id_reg - ID_W'(1);
        end else if (item_reg.set_valid) begin
            pend_id_next      = item_reg.set_session;
            pend_next         = 1'b1;
            out_next.set_taken = 1'b1;
        end else begin
            last_id_next = scan_ptr_reg;
            ex_waddr     = cur;
            if (item_reg.clear_valid) begin
                out_next.clear_taken = 1'b1;
            end else if (32'(scan_inc) >= 32'(SESSIONS)) begin
                scan_ptr_next = '0;
            end else begin
                scan_ptr_next = scan_inc[ID_W-1:0];
            end
            if (id_ok(cur) && ram_rdata.active && item_reg.event_ready) begin
                ex_we = 1'b1;
                if ((ram_rdata.count == '0) || item_reg.clear_valid) begin
                    out_next.event_valid   = 1'b1;
                    out_next.event_kind    = nodelay_mode_reg;
                    out_next.event_session = cur;
                end else begin
                    ex_wdata.active = 1'b1;
                    ex_wdata.count  = ram_rdata.count - COUNT_BITS'(1);
                end
            end
        end
    end

    // clearing pass writes zero, otherwise the item update
    always_comb begin
        if (cmd.sweep) begin
            ram_we    = 1'b1;
            ram_waddr = sweep_addr_reg;
            ram_wdata = '0;
        end else begin
            ram_we    = cmd.exec && ex_we;
            ram_waddr = ADDR_W'(ex_waddr);
            ram_wdata = ex_wdata;
        end
    end

    spt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SESSIONS)
    ) u_ram (
        .clk     (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ENTRY_W'(ram_wdata)),
        .rd_en   (cmd.accept),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata_raw)
    );

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            item_reg <= s_data;
        end
        if (cmd.exec) begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_ptr_reg       <= '0;
            pend_id_reg        <= '0;
            last_id_reg        <= '0;
            pend_reg           <= 1'b0;
            sweep_addr_reg     <= '0;
            probe_interval_reg <= PROBE_INTERVAL_RST;
            nodelay_mode_reg   <= 1'b0;
        end else begin
            if (cmd.sweep) begin
                sweep_addr_reg <= sweep_addr_reg + ADDR_W'(1);
            end
            if (cmd.exec) begin
                scan_ptr_reg <= scan_ptr_next;
                pend_id_reg  <= pend_id_next;
                last_id_reg  <= last_id_next;
                pend_reg     <= pend_next;
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_PROBE_INTERVAL: probe_interval_reg <= cfg_wr_data;
                    REG_NODELAY_MODE:   nodelay_mode_reg   <= cfg_wr_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    assign m_data = out_reg;

endmodule

/* rtl/session_probe_timer_table_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// session_probe_timer_table_top
// Per-session probe timer table with a round-robin scan. Each accepted item
// is one timer step and gives exactly one result item. The timer RAM read is
// registered when an item is accepted; the update and write-back happen in
// the execute state, which holds while the result output is stalled. After
// reset the block sweeps the 1024-entry timer RAM to zero, one entry per
// cycle, and holds s_ready low until the sweep is done; configuration
// writes are taken throughout.
// ----------------------------------------------------------------------------
module session_probe_timer_table_top
    import spt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  spt_in_t              s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output spt_out_t             m_data,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wr_data
);

    spt_cmd_t    cmd;
    spt_status_t status;

    spt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    spt_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .s_data      (s_data),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

endmodule

/* rtl/spt_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spt_checker
// Port-level checks for the probe timer table, bound to the top level.
// ----------------------------------------------------------------------------
`include "session_probe_timer_table_top_assert.svh"

module spt_checker
    import spt_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input spt_in_t  s_data,
    input logic     m_valid,
    input logic     m_ready,
    input spt_out_t m_data
);

    logic ev_fields_zero;
    logic set_alone;

    assign ev_fields_zero = !m_data.event_kind && (m_data.event_session == '0);
    assign set_alone      = !m_data.clear_taken && !m_data.event_valid;

    `SPT_ASSERT_ALWAYS(a_reset_quiet, aclk, !aresetn |=> !s_ready && !m_valid)

    `SPT_ASSERT(a_in_hold, aclk, aresetn, s_valid && !s_ready |=> s_valid && $stable(s_data))

    `SPT_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data))

    `SPT_ASSERT(a_no_event_zero, aclk, aresetn, m_valid && !m_data.event_valid |-> ev_fields_zero)

    `SPT_ASSERT(a_one_action, aclk, aresetn, m_valid && m_data.set_taken |-> set_alone)

endmodule

bind session_probe_timer_table_top spt_checker u_spt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the session probe timer table. A directed opening covers timer
// set, clear and scan corner cases; random phases under several interval and
// event-kind settings follow. Each accepted item steps a local copy of the
// timer table, and each result item is checked field by field against the
// oldest predicted result.
// ----------------------------------------------------------------------------
module tb_top;
    import spt_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    class probe_timer_tracker;
        spt_entry_t            timers [SESSIONS];
        logic [ID_W-1:0]       scan_ptr;
        logic [ID_W-1:0]       pend_id;
        logic [ID_W-1:0]       last_id;
        bit                    pend;
        logic [COUNT_BITS-1:0] interval;
        logic                  kind;
        spt_out_t              due_results [$];
        int                    errors;
        int                    checked;
        int                    events_seen;
        int                    expiries;

        function new();
            foreach (timers[i]) timers[i] = '0;
            scan_ptr = '0;
            pend_id  = '0;
            last_id  = '0;
            pend     = 1'b0;
            interval = PROBE_INTERVAL_RST[COUNT_BITS-1:0];
            kind     = 1'b0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            case (idx)
                REG_PROBE_INTERVAL: interval = value[COUNT_BITS-1:0];
                REG_NODELAY_MODE:   kind = value[0];
                default: ;
            endcase
        endfunction

        // one timer step for an accepted item
        function void take_step(spt_in_t it);
            spt_out_t        r;
            logic [ID_W-1:0] cur;
            bit              clearing;
            r = '0;
            if (pend) begin
                if (pend_id != last_id) begin
                    timers[pend_id] = {1'b1, interval};
                    pend = 1'b0;
                end
                last_id = last_id - 1'b1;
            end else if (it.set_valid) begin
                pend_id     = it.set_session;
                pend        = 1'b1;
                r.set_taken = 1'b1;
            end else begin
                cur      = scan_ptr;
                clearing = 1'b0;
                last_id  = scan_ptr;
                if (it.clear_valid) begin
                    cur           = it.clear_session;
                    clearing      = 1'b1;
                    r.clear_taken = 1'b1;
                end else begin
                    scan_ptr = (scan_ptr == ID_W'(SESSIONS - 1)) ? '0 : scan_ptr + 1'b1;
                end
                if (timers[cur].active && it.event_ready) begin
                    if (timers[cur].count == '0 || clearing) begin
                        timers[cur]     = '0;
                        r.event_valid   = 1'b1;
                        r.event_kind    = kind;
                        r.event_session = cur;
                    end else begin
                        timers[cur].count = timers[cur].count - 1'b1;
                    end
                end
            end
            due_results.push_back(r);
        endfunction

        function void cmp_field(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, actual %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_step_result(spt_out_t got);
            spt_out_t want;
            if (due_results.size() == 0) begin
                $error("result item %h with nothing expected", got);
                errors++;
                return;
            end
            want = due_results.pop_front();
            checked++;
            cmp_field("set_taken", want.set_taken, got.set_taken);
            cmp_field("clear_taken", want.clear_taken, got.clear_taken);
            cmp_field("event_valid", want.event_valid, got.event_valid);
            cmp_field("event_kind", want.event_kind, got.event_kind);
            cmp_field("event_session", want.event_session, got.event_session);
            if (want.event_valid) begin
                events_seen++;
                if (!want.clear_taken) expiries++;
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn     = 1'b0;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    spt_in_t              s_data      = '0;
    logic                 m_valid;
    logic                 m_ready     = 1'b0;
    spt_out_t             m_data;
    logic                 cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [CFG_W-1:0]     cfg_wr_data = '0;

    probe_timer_tracker tracker = new();
    bit                 fast_mode;
    bit                 long_hold_done;
    int                 items_sent;
    int                 cycle_count;
    logic [ID_W-1:0]    recent_sessions [$];

    session_probe_timer_table_top i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic spt_in_t make_item(bit sv, int ss, bit cv, int cs, bit rdy);
        spt_in_t it;
        it.set_valid     = sv;
        it.set_session   = ID_W'(ss);
        it.clear_valid   = cv;
        it.clear_session = ID_W'(cs);
        it.event_ready   = rdy;
        return it;
    endfunction

    function automatic spt_in_t random_item();
        spt_in_t it;
        int      pick;
        it   = $bits(spt_in_t)'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            // set just ahead of the scan so it expires soon
            it.set_valid   = 1'b1;
            it.set_session = tracker.scan_ptr + ID_W'($urandom_range(1, 6));
        end else if (pick < 32) begin
            it.set_valid   = 1'b1;
            it.set_session = tracker.last_id;
        end else if (pick < 40) begin
            it.set_valid = 1'b1;
        end else if (pick < 62) begin
            it.set_valid   = 1'b0;
            it.clear_valid = 1'b1;
            if (recent_sessions.size() != 0 && $urandom_range(0, 3) != 0)
                it.clear_session = recent_sessions[$urandom_range(0, recent_sessions.size() - 1)];
        end else begin
            it.set_valid   = 1'b0;
            it.clear_valid = 1'b0;
        end
        it.event_ready = ($urandom_range(0, 9) != 0);
        if (it.set_valid) begin
            recent_sessions.push_back(it.set_session);
            if (recent_sessions.size() > 16) void'(recent_sessions.pop_front());
        end
        return it;
    endfunction

    task automatic send_item(spt_in_t it);
        int gap;
        gap = fast_mode ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        tracker.take_step(it);
        items_sent++;
    endtask

    task automatic finish_pending();
        while (tracker.pend) send_item(random_item());
    endtask

    task automatic wait_results_done();
        s_valid <= 1'b0;
        while (tracker.due_results.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_config(logic [CFG_W-1:0] interval, logic kind);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= REG_PROBE_INTERVAL;
        cfg_wr_data <= interval;
        @(posedge aclk);
        cfg_index   <= REG_NODELAY_MODE;
        cfg_wr_data <= CFG_W'(kind);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        tracker.write_register(REG_PROBE_INTERVAL, interval);
        tracker.write_register(REG_NODELAY_MODE, CFG_W'(kind));
    endtask

    task automatic random_phase(int n, logic [CFG_W-1:0] interval, logic kind, bit fast);
        write_config(interval, kind);
        fast_mode = fast;
        repeat (n) send_item(random_item());
        wait_results_done();
    endtask

    // result side
    initial begin
        int stall;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            stall = fast_mode ? 0 : $urandom_range(0, 13);
            if (!long_hold_done && tracker.checked >= 230) begin
                stall          = 400;
                long_hold_done = 1'b1;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            tracker.check_step_result(m_data);
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("[session_probe_timer_table_top] ERROR");
        $finish;
    end

    initial begin
        logic [ID_W-1:0] base;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed, reset configuration
        send_item(make_item(0, 0, 0, 0, 0));
        send_item(make_item(0, 0, 1, 0, 1));
        // set and clear together, set on the last scanned session
        send_item(make_item(1, tracker.last_id, 1, 1023, 1));
        send_item(make_item(1, 1023, 1, 1023, 1));
        finish_pending();
        send_item(make_item(1, 1023, 0, 0, 1));
        finish_pending();
        // clear lost while sink busy, then clear with event
        send_item(make_item(0, 0, 1, 1023, 0));
        send_item(make_item(0, 0, 1, 1023, 1));
        base = tracker.scan_ptr;
        send_item(make_item(1, base + 1, 0, 0, 1));
        finish_pending();
        send_item(make_item(1, base + 2, 0, 0, 1));
        finish_pending();
        send_item(make_item(0, 0, 0, 0, 1));
        send_item(make_item(0, 0, 0, 0, 0));
        send_item(make_item(0, 0, 0, 0, 1));
        send_item(make_item(0, 0, 1, base + 1, 1));
        wait_results_done();

        // directed expiry with zero interval
        write_config('0, 1'b1);
        base = tracker.scan_ptr;
        send_item(make_item(1, base + 3, 0, 0, 1));
        finish_pending();
        repeat (4) send_item(make_item(0, 0, 0, 0, 1));
        wait_results_done();

        random_phase(125, '0, 1'b1, 1'b0);
        random_phase(125, CFG_W'(1), 1'b0, 1'b1);
        random_phase(125, CFG_W'(2), 1'b1, 1'b0);
        random_phase(125, '1, 1'b0, 1'b0);

        $display("tb_top: %0d items sent, %0d results checked, %0d events, %0d of them expiries",
                 items_sent, tracker.checked, tracker.events_seen, tracker.expiries);
        $display("tb_top: intervals 4883, 0, 1, 2 and max, both event kinds, long output hold");
        if (tracker.errors == 0 && tracker.due_results.size() == 0) begin
            $display("[session_probe_timer_table_top] OK");
        end else begin
            $display("[session_probe_timer_table_top] ERROR");
        end
        $finish;
    end

endmodule
